>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Uses the clock and reset names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CPD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/cpd_pkg.sv
// Types, constants and the CRC step shared by the packet deframer.
// No dependencies.
`default_nettype none

package cpd_pkg;

   localparam int DATA_BYTES_DEF = 32;
   localparam int HDR_BYTES      = 5;
   localparam int TRAILER_BYTES  = 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [7:0]  HDR_SYNC0 = 8'h41;  // 'A'
   localparam logic [7:0]  HDR_SYNC1 = 8'h56;  // 'V'
   localparam logic [7:0]  FIRST_INDEX = 8'd1;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   localparam logic REQ_BYTE    = 1'b0;
   localparam logic REQ_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_HEADER  = 3'd1,
      ST_BAD_CRC     = 3'd2,
      ST_FIRST_INDEX = 3'd3,
      ST_SEQUENCE    = 3'd4,
      ST_COUNT       = 3'd5,
      ST_TIMEOUT     = 3'd6
   } status_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } cpd_req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [4:0] byte_offset;
      logic [7:0] reply_code;
      logic [7:0] packet_index;
      logic [7:0] packet_count;
      status_type status;
      logic       last_of_packet;
      logic       message_done;
   } cpd_rsp_type;

   // one finished packet (or status) handed from front to back
   typedef struct packed {
      logic       is_data;
      logic       bank;
      logic [7:0] reply_code;
      logic [7:0] packet_index;
      logic [7:0] packet_count;
      status_type status;
      logic       done;
   } cpd_job_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } cpd_release_type;

   // CRC-16/XMODEM, one byte, msb first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cpd_queue.sv
// Short job queue between deframer front and back.
// Depends on cpd_pkg.
`default_nettype none

module cpd_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  logic                 push,
   input  cpd_pkg::cpd_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output cpd_pkg::cpd_job_type head
);

   localparam int DEPTH = cpd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cpd_pkg::cpd_job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

>>> hw/rtl/cpd_front.sv
// Deframer front: tracks byte position, header, CRC and message sequence,
// writes payload into the back's buffer and queues one job per packet or timeout.
// Depends on cpd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cpd_front #(
   parameter int DATA_BYTES = cpd_pkg::DATA_BYTES_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cpd_pkg::cpd_req_type                 req_data,
   input  logic                                 q_full,
   output logic                                 job_push,
   output cpd_pkg::cpd_job_type                 job_data,
   input  cpd_pkg::cpd_release_type             bank_release,
   output logic                                 wr_en,
   output logic [$clog2(2*DATA_BYTES)-1:0]      wr_addr,
   output logic [7:0]                           wr_data
);

   localparam int HDR   = cpd_pkg::HDR_BYTES;
   localparam int POS_W = $clog2(DATA_BYTES + HDR + cpd_pkg::TRAILER_BYTES);
   localparam int AW    = $clog2(2 * DATA_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       hdr_ff [HDR];
   logic [7:0]       hdr_in [HDR];
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [7:0]       rcvd_ff, rcvd_in;
   logic [7:0]       exp_ff, exp_in;
   logic             wr_bank_ff, wr_bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic             accept;
   logic             in_hdr, in_pay, at_crc_lo;
   logic [POS_W-1:0] pay_off;
   logic [15:0]      rx_crc;
   logic [7:0]       next_idx;
   logic [7:0]       new_rcvd, new_exp;
   cpd_pkg::status_type st;

   assign in_hdr    = pos_ff < POS_W'(HDR);
   assign in_pay    = !in_hdr && (pos_ff < POS_W'(HDR + DATA_BYTES));
   assign at_crc_lo = pos_ff == POS_W'(HDR + DATA_BYTES);
   assign req_stall = q_full || (in_pay && busy_ff[wr_bank_ff]);
   assign accept    = req_valid && !req_stall;

   assign pay_off = pos_ff - POS_W'(HDR);
   assign wr_addr = AW'(pay_off) + (wr_bank_ff ? AW'(DATA_BYTES) : AW'(0));
   assign wr_data = req_data.rx_byte;

   // end-of-packet checks: header, CRC, then sequence
   assign rx_crc   = {req_data.rx_byte, crc_lo_ff};
   assign next_idx = rcvd_ff + 8'd1;

   always_comb begin
      st       = cpd_pkg::ST_OK;
      new_rcvd = rcvd_ff;
      new_exp  = exp_ff;
      if (hdr_ff[0] != cpd_pkg::HDR_SYNC0 || hdr_ff[1] != cpd_pkg::HDR_SYNC1) begin
         st = cpd_pkg::ST_BAD_HEADER;
      end else if (rx_crc != crc_ff) begin
         st = cpd_pkg::ST_BAD_CRC;
      end else if (rcvd_ff == 8'd0) begin
         if (hdr_ff[3] != cpd_pkg::FIRST_INDEX) begin
            st = cpd_pkg::ST_FIRST_INDEX;
         end else begin
            new_rcvd = 8'd1;
            new_exp  = hdr_ff[4];
         end
      end else if (hdr_ff[3] != next_idx) begin
         st = cpd_pkg::ST_SEQUENCE;
      end else if (hdr_ff[4] != exp_ff) begin
         st = cpd_pkg::ST_COUNT;
      end else begin
         new_rcvd = next_idx;
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      hdr_in     = hdr_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;
      rcvd_in    = rcvd_ff;
      exp_in     = exp_ff;
      wr_bank_in = wr_bank_ff;
      busy_in    = busy_ff;
      wr_en      = 1'b0;
      job_push   = 1'b0;
      job_data   = '{is_data: 1'b0, bank: wr_bank_ff, reply_code: hdr_ff[2],
                     packet_index: hdr_ff[3], packet_count: hdr_ff[4],
                     status: st, done: 1'b0};

      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end

      if (accept) begin
         if (req_data.req_type == cpd_pkg::REQ_BYTE) begin
            if (in_hdr) begin
               hdr_in[pos_ff[2:0]] = req_data.rx_byte;
               pos_in = pos_ff + POS_W'(1);
            end else if (in_pay) begin
               wr_en  = 1'b1;
               crc_in = cpd_pkg::crc16_update(crc_ff, req_data.rx_byte);
               pos_in = pos_ff + POS_W'(1);
            end else if (at_crc_lo) begin
               crc_lo_in = req_data.rx_byte;
               pos_in    = pos_ff + POS_W'(1);
            end else begin
               pos_in   = '0;
               crc_in   = '0;
               job_push = 1'b1;
               if (st != cpd_pkg::ST_OK) begin
                  rcvd_in = 8'd0;
                  exp_in  = 8'd0;
               end else begin
                  job_data.is_data    = 1'b1;
                  job_data.done       = (new_rcvd == new_exp);
                  busy_in[wr_bank_ff] = 1'b1;
                  wr_bank_in          = !wr_bank_ff;
                  if (new_rcvd == new_exp) begin
                     rcvd_in = 8'd0;
                     exp_in  = 8'd0;
                  end else begin
                     rcvd_in = new_rcvd;
                     exp_in  = new_exp;
                  end
               end
            end
         end else if (pos_ff != '0 || rcvd_ff != 8'd0) begin
            // timeout with a packet or message under way
            job_push = 1'b1;
            job_data = '{is_data: 1'b0, bank: wr_bank_ff, reply_code: 8'd0,
                         packet_index: 8'd0, packet_count: 8'd0,
                         status: cpd_pkg::ST_TIMEOUT, done: 1'b0};
            pos_in   = '0;
            crc_in   = '0;
            rcvd_in  = 8'd0;
            exp_in   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= '0;
         rcvd_ff    <= '0;
         exp_ff     <= '0;
         wr_bank_ff <= 1'b0;
         busy_ff    <= '0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         rcvd_ff    <= rcvd_in;
         exp_ff     <= exp_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff    <= hdr_in;
      crc_lo_ff <= crc_lo_in;
   end

   `CPD_ASSERT_IMP(a_write_free_bank, wr_en, !busy_ff[wr_bank_ff], "payload write into busy bank")
   `CPD_ASSERT_IMP(a_push_room, job_push, !q_full, "job pushed into full queue")

endmodule

`default_nettype wire

>>> hw/rtl/cpd_back.sv
// Deframer back: holds the two-bank payload buffer and plays out one job
// at a time through a read stage and an output register.
// Depends on cpd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cpd_back #(
   parameter int DATA_BYTES = cpd_pkg::DATA_BYTES_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  logic                                 head_valid,
   input  cpd_pkg::cpd_job_type                 head,
   output logic                                 pop,
   output cpd_pkg::cpd_release_type             bank_release,
   input  logic                                 wr_en,
   input  logic [$clog2(2*DATA_BYTES)-1:0]      wr_addr,
   input  logic [7:0]                           wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cpd_pkg::cpd_rsp_type                 rsp_data
);

   localparam int AW    = $clog2(2 * DATA_BYTES);
   localparam int OFF_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

   logic [7:0] buf_mem [2*DATA_BYTES];

   logic [OFF_W-1:0]     cnt_ff, cnt_in;
   logic                 s1_valid_ff;
   logic                 s1_is_data_ff;
   cpd_pkg::cpd_rsp_type s1_ff, s1_in;
   logic [7:0]           rd_data_ff;
   logic                 out_valid_ff;
   cpd_pkg::cpd_rsp_type out_ff, out_in;

   logic            adv, issue, last_issue;
   logic [AW-1:0]   rd_addr;
   logic [4:0]      off_low;

   assign adv        = !out_valid_ff || !rsp_stall;
   assign issue      = adv && head_valid;
   assign last_issue = !head.is_data || (cnt_ff == OFF_W'(DATA_BYTES - 1));
   assign pop        = issue && last_issue;
   assign bank_release = '{valid: pop && head.is_data, bank: head.bank};

   assign rd_addr = AW'(cnt_ff) + (head.bank ? AW'(DATA_BYTES) : AW'(0));
   // offset field keeps the low five bits of the position
   assign off_low = 5'(cnt_ff);

   always_comb begin
      cnt_in = cnt_ff;
      if (issue && head.is_data) begin
         cnt_in = last_issue ? '0 : cnt_ff + OFF_W'(1);
      end
      s1_in = '{data_byte: 8'd0,
                byte_offset: head.is_data ? off_low : 5'd0,
                reply_code: head.reply_code,
                packet_index: head.packet_index,
                packet_count: head.packet_count,
                status: head.status,
                last_of_packet: last_issue,
                message_done: last_issue && head.done};
      out_in = s1_ff;
      out_in.data_byte = s1_is_data_ff ? rd_data_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= buf_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (adv) begin
            s1_valid_ff  <= issue;
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff         <= s1_in;
         s1_is_data_ff <= head.is_data;
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `CPD_ASSERT_IMP(a_done_on_last, rsp_valid && rsp_data.message_done,
                   rsp_data.last_of_packet, "message_done off the last beat")
   `CPD_ASSERT_IMP(a_status_beat, rsp_valid && rsp_data.status != cpd_pkg::ST_OK,
                   rsp_data.last_of_packet && rsp_data.data_byte == 8'd0,
                   "status beat not single or carries data")

endmodule

`default_nettype wire

>>> hw/rtl/crc_checked_packet_deframer_unit.sv
// Top level of the CRC-checked packet deframer.
// Depends on cpd_pkg, cpd_front, cpd_queue and cpd_back.
//
//   channel  ports                          beat
//   req      req_valid/req_stall/req_data   one rx byte or timeout tick
//   rsp      rsp_valid/rsp_stall/rsp_data   one payload byte or status
//
// One req beat per cycle unless stalled; a good packet plays out DATA_BYTES
// rsp beats, one per cycle unless rsp_stall holds them.
// The payload buffer has two banks: a packet's payload bytes stall while the
// bank they need still plays out an earlier packet; a full two-entry job
// queue stalls every req beat.
// Reset is synchronous; the payload buffer is not cleared.
`default_nettype none

module crc_checked_packet_deframer_unit #(
   parameter int DATA_BYTES = cpd_pkg::DATA_BYTES_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cpd_pkg::cpd_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cpd_pkg::cpd_rsp_type  rsp_data
);

   localparam int AW = $clog2(2 * DATA_BYTES);

   logic                     q_full;
   logic                     job_push;
   cpd_pkg::cpd_job_type     job_data;
   logic                     job_pop;
   logic                     head_valid;
   cpd_pkg::cpd_job_type     head;
   cpd_pkg::cpd_release_type bank_release;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [7:0]               wr_data;

   cpd_front #(.DATA_BYTES(DATA_BYTES)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .q_full       (q_full),
      .job_push     (job_push),
      .job_data     (job_data),
      .bank_release (bank_release),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   cpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_data),
      .full       (q_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   cpd_back #(.DATA_BYTES(DATA_BYTES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (job_pop),
      .bank_release (bank_release),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire
